// File: rtl/tpib_pkg.sv
package tpib_pkg;

    localparam int DEPTH_DEF = 64;
    localparam int RATIO_FRAC_BITS_DEF = 16;

    localparam int STAMP_W = 63;
    localparam int LIMIT_W = 36;
    localparam int TOL_W = 32;
    localparam int CFG_DATA_W = 36;
    localparam int CFG_IDX_W = 1;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 36'd5000000000;
    localparam logic [TOL_W-1:0] TOL_RESET = 32'd100000000;

    localparam logic [CFG_IDX_W-1:0] CFG_HISTORY_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_TOL = 1'd1;

    localparam logic [1:0] FN_APPEND = 2'd0;
    localparam logic [1:0] FN_PRUNE = 2'd1;
    localparam logic [1:0] FN_LOOKUP = 2'd2;

    localparam logic [2:0] ST_INTERP = 3'd0;
    localparam logic [2:0] ST_CLAMP_OLD = 3'd1;
    localparam logic [2:0] ST_CLAMP_NEW = 3'd2;
    localparam logic [2:0] ST_EMPTY = 3'd3;
    localparam logic [2:0] ST_EARLY = 3'd4;
    localparam logic [2:0] ST_LATE = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    typedef struct packed {
        logic [STAMP_W-1:0] stamp;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] h;
    } t_entry;

endpackage

// File: rtl/tpib_mem.sv
module tpib_mem #(
    parameter int DEPTH = tpib_pkg::DEPTH_DEF,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  tpib_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output tpib_pkg::t_entry  o_rdata
);

    tpib_pkg::t_entry r_mem [DEPTH];
    tpib_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/tpib_div.sv
module tpib_div #(
    parameter int RATIO_FRAC_BITS = tpib_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [tpib_pkg::STAMP_W-1:0]        i_num,
    input  logic [tpib_pkg::STAMP_W-1:0]        i_den,
    output logic                                o_done,
    output logic [RATIO_FRAC_BITS-1:0]          o_quot
);

    localparam int NW = $clog2(RATIO_FRAC_BITS + 1);

    logic [tpib_pkg::STAMP_W:0]   r_rem;
    logic [tpib_pkg::STAMP_W-1:0] r_den;
    logic [RATIO_FRAC_BITS-1:0]   r_quot;
    logic [NW-1:0]                r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [tpib_pkg::STAMP_W:0]   w_shift;
    logic                         w_ge;

    assign w_shift = {r_rem[tpib_pkg::STAMP_W-1:0], 1'b0};
    assign w_ge = w_shift >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= r_busy && !i_start && (r_cnt == NW'(RATIO_FRAC_BITS - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= '0;
                r_rem <= {1'b0, i_num};
                r_den <= i_den;
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_shift - {1'b0, r_den}) : w_shift;
                r_quot <= {r_quot[RATIO_FRAC_BITS-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == NW'(RATIO_FRAC_BITS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/timestamped_pose_interpolation_buffer.sv
// Channel  | Direction | Handshake                    | Payload
// request  | in        | i_in_valid / o_in_ready      | i_func, i_stamp_ns, i_pos_x, i_pos_y, i_heading
// result   | out       | o_out_valid / i_out_ready    | o_status, o_out_x, o_out_y, o_out_heading, o_entries
// config   | in        | i_cfg_we, i_cfg_idx          | i_cfg_data
// Append writes the new entry as the request is accepted. Prune drops the oldest entry while
// it is older than the request stamp by more than the history limit, and stops at a newer
// entry or an empty ring. A lookup reads the oldest and newest entries; an interpolating one
// then scans the entries in turn, runs the shared divider for the ratio when needed and does
// a multiply and an add for each of x, y and heading. The pose memory has a single read port.
// Reset is synchronous and active low and empties the ring; no clearing pass is needed.
// A finished result is held until taken; a new request may be accepted meanwhile, but its result waits for that.
module timestamped_pose_interpolation_buffer #(
    parameter int DEPTH = tpib_pkg::DEPTH_DEF,
    parameter int RATIO_FRAC_BITS = tpib_pkg::RATIO_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [tpib_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [tpib_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [1:0]                           i_func,
    input  logic [tpib_pkg::STAMP_W-1:0]         i_stamp_ns,
    input  logic signed [31:0]                   i_pos_x,
    input  logic signed [31:0]                   i_pos_y,
    input  logic signed [15:0]                   i_heading,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [2:0]                           o_status,
    output logic signed [31:0]                   o_out_x,
    output logic signed [31:0]                   o_out_y,
    output logic signed [15:0]                   o_out_heading,
    output logic [6:0]                           o_entries
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = AW + 1;
    localparam int RW = RATIO_FRAC_BITS + 1;
    localparam int PW = 33 + RW + 1;
    localparam int SW = tpib_pkg::STAMP_W;

    typedef enum logic [3:0] {
        S_IDLE, S_PR_RD, S_PR_CHK, S_LK_RDF, S_LK_RDB, S_LK_CMP,
        S_SC_RD, S_SC_CHK, S_DIV_GO, S_DIV, S_MUL, S_ADD, S_OUT
    } t_state;

    t_state r_state;
    logic [tpib_pkg::LIMIT_W-1:0] r_limit;
    logic [tpib_pkg::TOL_W-1:0]   r_tol;
    logic [AW-1:0]                r_oldest;
    logic [CW-1:0]                r_count;
    logic [AW-1:0]                r_idx;
    logic [SW-1:0]                r_stamp;
    tpib_pkg::t_entry             r_prev;
    tpib_pkg::t_entry             r_cur;
    logic [RW-1:0]                r_ratio;
    logic signed [PW-1:0]         r_prod;
    logic [1:0]                   r_lane;
    logic [2:0]                   r_res_status;
    logic signed [31:0]           r_res_x;
    logic signed [31:0]           r_res_y;
    logic signed [15:0]           r_res_h;
    logic                         r_ovalid;
    logic [2:0]                   r_ostatus;
    logic signed [31:0]           r_ox;
    logic signed [31:0]           r_oy;
    logic signed [15:0]           r_oh;
    logic [6:0]                   r_oentries;
    logic [SW-1:0]                r_num;
    logic [SW-1:0]                r_den;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    tpib_pkg::t_entry             w_wdata;
    logic [AW-1:0]                w_raddr;
    tpib_pkg::t_entry             w_rdata;
    logic                         w_div_start;
    logic                         w_div_done;
    logic [RATIO_FRAC_BITS-1:0]   w_quot;
    logic                         w_accept;
    logic [CW-1:0]                w_app_cnt;
    logic [AW-1:0]                w_app_old;
    logic signed [32:0]           w_delta;
    logic signed [PW-1:0]         w_shifted;
    logic [SW-1:0]                w_dnum;
    logic [SW-1:0]                w_dden;

    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH)) begin
            sum = sum - (AW+1)'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    tpib_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tpib_div #(.RATIO_FRAC_BITS(RATIO_FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_div_start = (r_state == S_DIV_GO);

    always_comb begin
        if (r_count == CW'(DEPTH)) begin
            w_app_cnt = CW'(DEPTH - 1);
            w_app_old = (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
        end else begin
            w_app_cnt = r_count;
            w_app_old = r_oldest;
        end
    end

    assign w_we = w_accept && (i_func == tpib_pkg::FN_APPEND);
    assign w_waddr = f_wrap(w_app_old, w_app_cnt[AW-1:0]);
    assign w_wdata = '{stamp: i_stamp_ns, x: i_pos_x, y: i_pos_y, h: i_heading};

    always_comb begin
        case (r_state)
            S_LK_RDB: w_raddr = f_wrap(r_oldest, AW'(r_count - 1'b1));
            S_SC_RD:  w_raddr = f_wrap(r_oldest, r_idx);
            default:  w_raddr = r_oldest;
        endcase
    end

    always_comb begin
        case (r_lane)
            2'd0:    w_delta = {r_cur.x[31], r_cur.x} - {r_prev.x[31], r_prev.x};
            2'd1:    w_delta = {r_cur.y[31], r_cur.y} - {r_prev.y[31], r_prev.y};
            default: w_delta = 33'(signed'(16'(r_cur.h - r_prev.h)));
        endcase
    end

    assign w_shifted = r_prod >>> RATIO_FRAC_BITS;
    assign w_dnum = r_stamp - r_prev.stamp;
    assign w_dden = w_rdata.stamp - r_prev.stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_limit <= tpib_pkg::LIMIT_RESET;
            r_tol <= tpib_pkg::TOL_RESET;
            r_oldest <= '0;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    tpib_pkg::CFG_HISTORY_LIMIT: r_limit <= i_cfg_data[tpib_pkg::LIMIT_W-1:0];
                    tpib_pkg::CFG_CLAMP_TOL:     r_tol <= i_cfg_data[tpib_pkg::TOL_W-1:0];
                    default: ;
                endcase
            end
            if (r_ovalid && i_out_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_stamp <= i_stamp_ns;
                        r_res_status <= (i_func == tpib_pkg::FN_LOOKUP && r_count == '0)
                                        ? tpib_pkg::ST_EMPTY : tpib_pkg::ST_DONE;
                        r_res_x <= '0;
                        r_res_y <= '0;
                        r_res_h <= '0;
                        case (i_func)
                            tpib_pkg::FN_APPEND: begin
                                r_oldest <= w_app_old;
                                r_count <= w_app_cnt + 1'b1;
                                r_state <= S_OUT;
                            end
                            tpib_pkg::FN_PRUNE:  r_state <= S_PR_RD;
                            tpib_pkg::FN_LOOKUP: begin
                                r_state <= (r_count == '0) ? S_OUT : S_LK_RDF;
                            end
                            default: r_state <= S_OUT;
                        endcase
                    end
                end
                S_PR_RD: begin
                    r_state <= (r_count == '0) ? S_OUT : S_PR_CHK;
                end
                S_PR_CHK: begin
                    if (r_stamp > w_rdata.stamp &&
                        (r_stamp - w_rdata.stamp) > SW'(r_limit)) begin
                        r_oldest <= (r_oldest == AW'(DEPTH - 1)) ? '0 : r_oldest + 1'b1;
                        r_count <= r_count - 1'b1;
                        r_state <= S_PR_RD;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_LK_RDF: r_state <= S_LK_RDB;
                S_LK_RDB: begin
                    r_prev <= w_rdata;
                    r_state <= S_LK_CMP;
                end
                S_LK_CMP: begin
                    if (r_stamp <= r_prev.stamp) begin
                        r_state <= S_OUT;
                        if ((r_prev.stamp - r_stamp) <= SW'(r_tol)) begin
                            r_res_status <= tpib_pkg::ST_CLAMP_OLD;
                            r_res_x <= r_prev.x;
                            r_res_y <= r_prev.y;
                            r_res_h <= r_prev.h;
                        end else begin
                            r_res_status <= tpib_pkg::ST_EARLY;
                        end
                    end else if (r_stamp >= w_rdata.stamp) begin
                        r_state <= S_OUT;
                        if ((r_stamp - w_rdata.stamp) <= SW'(r_tol)) begin
                            r_res_status <= tpib_pkg::ST_CLAMP_NEW;
                            r_res_x <= w_rdata.x;
                            r_res_y <= w_rdata.y;
                            r_res_h <= w_rdata.h;
                        end else begin
                            r_res_status <= tpib_pkg::ST_LATE;
                        end
                    end else begin
                        r_idx <= AW'(1);
                        r_state <= S_SC_RD;
                    end
                end
                S_SC_RD: r_state <= S_SC_CHK;
                S_SC_CHK: begin
                    r_cur <= w_rdata;
                    if (r_stamp > w_rdata.stamp) begin
                        r_prev <= w_rdata;
                        r_idx <= r_idx + 1'b1;
                        if (CW'(r_idx) + 1'b1 == r_count) begin
                            r_res_status <= tpib_pkg::ST_LATE;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SC_RD;
                        end
                    end else begin
                        r_res_status <= tpib_pkg::ST_INTERP;
                        if (w_rdata.stamp <= r_prev.stamp || w_dden <= SW'(1)) begin
                            r_res_x <= w_rdata.x;
                            r_res_y <= w_rdata.y;
                            r_res_h <= w_rdata.h;
                            r_state <= S_OUT;
                        end else begin
                            r_lane <= 2'd0;
                            if (w_dnum >= w_dden) begin
                                r_ratio <= RW'(1) << RATIO_FRAC_BITS;
                                r_state <= S_MUL;
                            end else begin
                                r_num <= w_dnum;
                                r_den <= w_dden;
                                r_state <= S_DIV_GO;
                            end
                        end
                    end
                end
                S_DIV_GO: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div_done) begin
                        r_ratio <= {1'b0, w_quot};
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod <= PW'(w_delta) * PW'(signed'({1'b0, r_ratio}));
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    case (r_lane)
                        2'd0:    r_res_x <= r_prev.x + w_shifted[31:0];
                        2'd1:    r_res_y <= r_prev.y + w_shifted[31:0];
                        default: r_res_h <= r_prev.h + w_shifted[15:0];
                    endcase
                    r_lane <= r_lane + 1'b1;
                    r_state <= (r_lane == 2'd2) ? S_OUT : S_MUL;
                end
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_ostatus <= r_res_status;
                        r_ox <= r_res_x;
                        r_oy <= r_res_y;
                        r_oh <= r_res_h;
                        r_oentries <= 7'(r_count);
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_status = r_ostatus;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_heading = r_oh;
    assign o_entries = r_oentries;

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam logic [1:0] FN_SPARE = 2'd3;
    localparam int RING = 64;
    localparam int STALL_LIMIT = 100000;

    typedef struct packed {
        logic [2:0] status;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] h;
        logic [6:0] entries;
    } t_pose_result;

    class PoseHistoryScoreboard;
        logic [tpib_pkg::STAMP_W-1:0] st[RING];
        logic signed [31:0] xs[RING];
        logic signed [31:0] ys[RING];
        logic signed [15:0] hs[RING];
        int head;
        int cnt;
        logic [tpib_pkg::LIMIT_W-1:0] limit;
        logic [tpib_pkg::TOL_W-1:0] tol;
        t_pose_result due[$];
        int errors;

        function new();
            head = 0;
            cnt = 0;
            limit = tpib_pkg::LIMIT_RESET;
            tol = tpib_pkg::TOL_RESET;
            errors = 0;
        endfunction

        function int slot(int k);
            return (head + k) % RING;
        endfunction

        function logic [tpib_pkg::STAMP_W-1:0] front_stamp();
            return st[slot(0)];
        endfunction

        function logic [tpib_pkg::STAMP_W-1:0] back_stamp();
            return st[slot(cnt - 1)];
        endfunction

        function int pending();
            return due.size();
        endfunction

        function logic [16:0] ratio_of(logic [tpib_pkg::STAMP_W-1:0] num,
                                       logic [tpib_pkg::STAMP_W-1:0] den);
            logic [63:0] rem;
            logic [16:0] q;
            if (num >= den) begin
                return 17'h10000;
            end
            rem = {1'b0, num};
            q = 0;
            for (int k = 0; k < 16; k++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= {1'b0, den}) begin
                    rem = rem - {1'b0, den};
                    q[0] = 1'b1;
                end
            end
            return q;
        endfunction

        function void note_request(logic [1:0] fn, logic [tpib_pkg::STAMP_W-1:0] s,
                                   logic signed [31:0] x, logic signed [31:0] y,
                                   logic signed [15:0] h);
            t_pose_result r;
            int f;
            int b;
            int p;
            int a;
            longint rt;
            logic signed [15:0] dh;
            r = '0;
            r.status = tpib_pkg::ST_DONE;
            if (fn == tpib_pkg::FN_APPEND) begin
                if (cnt >= RING) begin
                    head = (head + 1) % RING;
                    cnt = RING - 1;
                end
                a = slot(cnt);
                st[a] = s;
                xs[a] = x;
                ys[a] = y;
                hs[a] = h;
                cnt++;
            end else if (fn == tpib_pkg::FN_PRUNE) begin
                while (cnt > 0 && s > front_stamp() && (s - front_stamp()) > limit) begin
                    head = (head + 1) % RING;
                    cnt--;
                end
            end else if (fn == tpib_pkg::FN_LOOKUP) begin
                if (cnt == 0) begin
                    r.status = tpib_pkg::ST_EMPTY;
                end else begin
                    f = slot(0);
                    b = slot(cnt - 1);
                    if (s <= st[f]) begin
                        if (st[f] - s <= tol) begin
                            r.status = tpib_pkg::ST_CLAMP_OLD;
                            r.x = xs[f];
                            r.y = ys[f];
                            r.h = hs[f];
                        end else begin
                            r.status = tpib_pkg::ST_EARLY;
                        end
                    end else if (s >= st[b]) begin
                        if (s - st[b] <= tol) begin
                            r.status = tpib_pkg::ST_CLAMP_NEW;
                            r.x = xs[b];
                            r.y = ys[b];
                            r.h = hs[b];
                        end else begin
                            r.status = tpib_pkg::ST_LATE;
                        end
                    end else begin
                        r.status = tpib_pkg::ST_LATE;
                        for (int i = 1; i < cnt; i++) begin
                            p = slot(i - 1);
                            a = slot(i);
                            if (s <= st[a]) begin
                                r.status = tpib_pkg::ST_INTERP;
                                if (st[a] <= st[p] || st[a] - st[p] <= 1) begin
                                    r.x = xs[a];
                                    r.y = ys[a];
                                    r.h = hs[a];
                                end else begin
                                    rt = longint'(ratio_of(s - st[p], st[a] - st[p]));
                                    dh = hs[a] - hs[p];
                                    r.x = 32'(longint'(xs[p])
                                        + ((rt * (longint'(xs[a]) - longint'(xs[p]))) >>> 16));
                                    r.y = 32'(longint'(ys[p])
                                        + ((rt * (longint'(ys[a]) - longint'(ys[p]))) >>> 16));
                                    r.h = 16'(longint'(hs[p]) + ((rt * longint'(dh)) >>> 16));
                                end
                                break;
                            end
                        end
                        if (r.status == tpib_pkg::ST_LATE) begin
                            r.x = 0;
                            r.y = 0;
                            r.h = 0;
                        end
                    end
                end
            end
            r.entries = 7'(cnt);
            due.push_back(r);
        endfunction

        function void check_result(t_pose_result got);
            t_pose_result want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: status %0d x %0d y %0d h %0d entries %0d",
                             got.status, got.x, got.y, got.h, got.entries);
                end
                return;
            end
            want = due[0];
            due.delete(0);
            if (got !== want) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected status %0d x %0d y %0d h %0d entries %0d",
                             want.status, want.x, want.y, want.h, want.entries);
                    $display("          actual   status %0d x %0d y %0d h %0d entries %0d",
                             got.status, got.x, got.y, got.h, got.entries);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [tpib_pkg::CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [tpib_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [1:0] i_func = tpib_pkg::FN_APPEND;
    logic [tpib_pkg::STAMP_W-1:0] i_stamp_ns = '0;
    logic signed [31:0] i_pos_x = '0;
    logic signed [31:0] i_pos_y = '0;
    logic signed [15:0] i_heading = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic [2:0] o_status;
    logic signed [31:0] o_out_x;
    logic signed [31:0] o_out_y;
    logic signed [15:0] o_out_heading;
    logic [6:0] o_entries;

    timestamped_pose_interpolation_buffer dut (.*);

    PoseHistoryScoreboard poses = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    logic [tpib_pkg::STAMP_W-1:0] t_now = 63'd1000000000;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        if (hold_seen != hold_asks) begin
            hold_seen <= hold_asks;
            hold_left <= 600;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) begin
            poses.note_request(i_func, i_stamp_ns, i_pos_x, i_pos_y, i_heading);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            poses.check_result({o_status, o_out_x, o_out_y, o_out_heading, o_entries});
        end
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(logic [1:0] fn, logic [tpib_pkg::STAMP_W-1:0] s,
                        logic signed [31:0] x, logic signed [31:0] y,
                        logic signed [15:0] h);
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_func <= fn;
        i_stamp_ns <= s;
        i_pos_x <= x;
        i_pos_y <= y;
        i_heading <= h;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (poses.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [tpib_pkg::CFG_IDX_W-1:0] idx,
                             logic [tpib_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        if (idx == tpib_pkg::CFG_HISTORY_LIMIT) begin
            poses.limit = data;
        end else begin
            poses.tol = data[tpib_pkg::TOL_W-1:0];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_random();
        logic [1:0] fn;
        logic [tpib_pkg::STAMP_W-1:0] s;
        logic [tpib_pkg::STAMP_W-1:0] lo;
        logic [tpib_pkg::STAMP_W-1:0] hi;
        logic [63:0] reach;
        int pick;
        pick = $urandom_range(99);
        if (pick < 12) begin
            fn = 2'($urandom_range(3));
            s = ($urandom_range(1)) ? 63'(rand64()) : t_now + $urandom_range(1000);
        end else if (pick < 55) begin
            fn = tpib_pkg::FN_APPEND;
            case ($urandom_range(19))
                0: t_now = t_now;
                1: t_now = t_now + 1;
                2: t_now = t_now + 2;
                default: t_now = t_now + $urandom_range(300000000, 1);
            endcase
            s = t_now;
        end else if (pick < 65) begin
            fn = tpib_pkg::FN_PRUNE;
            s = t_now + $urandom_range(2000000000);
        end else begin
            fn = tpib_pkg::FN_LOOKUP;
            if (poses.cnt == 0) begin
                s = t_now;
            end else begin
                lo = poses.front_stamp();
                hi = poses.back_stamp();
                reach = 2 * {32'b0, poses.tol} + 3;
                case ($urandom_range(3))
                    0: s = (lo > reach) ? lo - 63'(rand64() % reach) : 63'(rand64() % reach);
                    1: s = hi + 63'(rand64() % reach);
                    default: s = (hi > lo) ? lo + 63'(rand64() % (hi - lo + 1)) : lo;
                endcase
            end
        end
        send(fn, s, $urandom, $urandom, 16'($urandom));
    endtask

    initial begin
        logic [tpib_pkg::STAMP_W-1:0] base;
        base = 63'd1000000000;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send(tpib_pkg::FN_LOOKUP, '0, 0, 0, 0);
        send(tpib_pkg::FN_PRUNE, base, 0, 0, 0);
        send(tpib_pkg::FN_APPEND, base, 32'h7fffffff, 32'h80000000, 16'h7fff);
        send(tpib_pkg::FN_LOOKUP, base, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base - 100000000, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base - 100000001, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base + 100000000, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base + 100000001, 0, 0, 0);
        send(tpib_pkg::FN_APPEND, base + 1000, 32'h80000000, 32'h7fffffff, 16'h8000);
        send(tpib_pkg::FN_LOOKUP, base + 500, 0, 0, 0);
        send(tpib_pkg::FN_APPEND, base + 1000, 1, -1, 16'h0001);
        send(tpib_pkg::FN_APPEND, base + 1001, -5, 5, 16'hffff);
        send(tpib_pkg::FN_APPEND, base + 3000, 1000, -1000, 16'h4000);
        send(tpib_pkg::FN_LOOKUP, base + 1000, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base + 1001, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base + 2999, 0, 0, 0);
        send(tpib_pkg::FN_APPEND, base + 500, 7, 7, 16'hc000);
        send(tpib_pkg::FN_APPEND, base + 4000, -7, -7, 16'h3fff);
        send(tpib_pkg::FN_LOOKUP, base + 3500, 0, 0, 0);
        send(FN_SPARE, '1, -1, -1, 16'hffff);
        send(tpib_pkg::FN_PRUNE, base + 63'd5000000600, 0, 0, 0);
        send(tpib_pkg::FN_LOOKUP, base + 3500, 0, 0, 0);
        send(tpib_pkg::FN_APPEND, '1, 32'h55555555, 32'haaaaaaaa, 16'h5555);
        send(tpib_pkg::FN_LOOKUP, '1, 0, 0, 0);
        send(tpib_pkg::FN_PRUNE, '1, 0, 0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            drain();
            case (phase)
                0: begin
                    write_reg(tpib_pkg::CFG_HISTORY_LIMIT, 36'd5000000000);
                    write_reg(tpib_pkg::CFG_CLAMP_TOL, 36'd100000000);
                end
                1: begin
                    send_idle_pct = 85;
                    recv_stall_pct = 0;
                    write_reg(tpib_pkg::CFG_HISTORY_LIMIT, '0);
                    write_reg(tpib_pkg::CFG_CLAMP_TOL, '0);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 85;
                    write_reg(tpib_pkg::CFG_HISTORY_LIMIT, {tpib_pkg::LIMIT_W{1'b1}});
                    write_reg(tpib_pkg::CFG_CLAMP_TOL, 36'hffffffff);
                end
                default: begin
                    send_idle_pct = 21;
                    recv_stall_pct = 21;
                    write_reg(tpib_pkg::CFG_HISTORY_LIMIT, 36'd2000000000);
                    write_reg(tpib_pkg::CFG_CLAMP_TOL, 36'd5000000);
                end
            endcase
            for (int n = 0; n < 306; n++) begin
                if (phase == 0 && n == 150) begin
                    hold_asks = hold_asks + 1;
                end
                if (phase == 2 && n == 150) begin
                    drain();
                end
                send_random();
            end
        end

        drain();
        repeat (400) @(posedge i_clk);
        if (poses.errors == 0 && poses.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/tpib_pkg.sv
rtl/tpib_mem.sv
rtl/tpib_div.sv
rtl/timestamped_pose_interpolation_buffer.sv
bench/tb.sv
